>>> design/wrv_pkg.sv
// Shared types and constants for the word reverser with tag passthrough.
// Holds character codes, default sizes and the result word struct.
// Depends on nothing; every other design file imports it.
`timescale 1ns / 1ps

package wrv_pkg;

  localparam int CHAR_W = 8;
  localparam int STACK_DEPTH_DEF = 63;

  // Character codes that steer the block.
  localparam logic [CHAR_W-1:0] CH_OPEN  = 8'd60;
  localparam logic [CHAR_W-1:0] CH_CLOSE = 8'd62;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'd32;
  localparam logic [CHAR_W-1:0] CH_NL    = 8'd10;

  // One result word as handed from the controller to the output register.
  typedef struct packed {
    logic [CHAR_W-1:0] char_out;
    logic              last_of_run;
    logic              overflow_seen;
  } emit_t;

endpackage

>>> design/wrv_stack_mem.sv
// Character stack storage: one write port and one read port, read data registered.
// Depends on wrv_pkg for the character width.
`timescale 1ns / 1ps

module wrv_stack_mem #(
  parameter int DEPTH = wrv_pkg::STACK_DEPTH_DEF,
  parameter int AW    = 6
) (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [AW-1:0]             wr_addr,
  input  logic [wrv_pkg::CHAR_W-1:0] wr_data,
  input  logic                      rd_en,
  input  logic [AW-1:0]             rd_addr,
  output logic [wrv_pkg::CHAR_W-1:0] rd_data_r
);
  import wrv_pkg::*;

  logic [CHAR_W-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port; data holds until the next read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

endmodule

>>> design/wrv_out_reg.sv
// Output register that parts the controller from the result stream.
// Depends on wrv_pkg for the result word struct.
`timescale 1ns / 1ps

module wrv_out_reg (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      load,
  input  wrv_pkg::emit_t            emit,
  output logic                      slot_free,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [7:0]                out_tdata,
  output logic                      out_tlast,
  output logic                      out_tuser
);
  import wrv_pkg::*;

  logic  valid_r;
  emit_t data_r;

  assign slot_free  = !valid_r || out_tready;
  assign out_tvalid = valid_r;
  assign out_tdata  = data_r.char_out;
  assign out_tlast  = data_r.last_of_run;
  assign out_tuser  = data_r.overflow_seen;

  // Valid flag: set on load, cleared when the word is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_tready) begin
      valid_r <= 1'b0;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= emit;
    end
  end

endmodule

>>> design/word_reverser_with_tag_passthrough_unit.sv
// A pushed character is written to the stack on acceptance and gives no word. A flush pops
// the stacked characters through the memory read register into the output register, one word
// per cycle while the output is not stalled, and then sends its trailing character, if any;
// a passthrough word goes from S_EMIT into the output register. Input is taken only in S_IDLE,
// so a new character waits until the flush or passthrough word has been handed on.
// Synchronous active-low reset empties the stack and clears the tag and overflow flags.
`timescale 1ns / 1ps

module word_reverser_with_tag_passthrough_unit #(
  parameter int STACK_DEPTH = wrv_pkg::STACK_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] char_in
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] char_out
  output logic       out_tlast,  // last_of_run
  output logic       out_tuser   // overflow_seen
);
  import wrv_pkg::*;

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_POP,
    S_EMIT
  } state_t;

  state_t            state_r, state_nxt;
  logic [CHAR_W-1:0] ch_r, ch_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic              tag_r, tag_nxt;
  logic              ovf_r, ovf_nxt;
  logic              emit_ch_r, emit_ch_nxt;

  logic              acc;
  logic              is_open, is_close, is_space, is_nl;
  logic              wr_en, rd_en;
  logic [AW-1:0]     rd_addr;
  logic [CHAR_W-1:0] rd_data;
  logic              slot_free;
  logic              load;
  emit_t             emit;

  assign in_tready = (state_r == S_IDLE);
  assign acc       = in_tvalid && in_tready;
  assign is_open   = (in_tdata == CH_OPEN);
  assign is_close  = (in_tdata == CH_CLOSE);
  assign is_space  = (in_tdata == CH_SPACE);
  assign is_nl     = (in_tdata == CH_NL);
  assign rd_addr   = AW'(count_r - CW'(1));

  // Next-state logic: classify the accepted word, push, or run the flush.
  always_comb begin
    state_nxt   = state_r;
    ch_nxt      = ch_r;
    count_nxt   = count_r;
    tag_nxt     = tag_r;
    ovf_nxt     = ovf_r;
    emit_ch_nxt = emit_ch_r;
    wr_en       = 1'b0;
    rd_en       = 1'b0;
    load        = 1'b0;
    emit        = '{char_out: rd_data, last_of_run: 1'b0, overflow_seen: ovf_r};
    unique case (state_r)
      S_IDLE: begin
        if (acc) begin
          ch_nxt = in_tdata;
          priority if (is_close || (tag_r && !is_open)) begin
            // Passthrough: a close mark, or any character inside a tag.
            if (is_close) begin
              tag_nxt = 1'b0;
            end
            state_nxt = S_EMIT;
          end else if (is_open || is_space || is_nl) begin
            // Flush, then optionally send the character itself.
            if (is_open) begin
              tag_nxt = 1'b1;
            end
            emit_ch_nxt = !is_nl;
            if (count_r != '0) begin
              rd_en     = 1'b1;
              count_nxt = count_r - CW'(1);
              state_nxt = S_POP;
            end else if (!is_nl) begin
              state_nxt = S_EMIT;
            end
          end else if (count_r < CW'(STACK_DEPTH)) begin
            wr_en     = 1'b1;
            count_nxt = count_r + CW'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
        end
      end
      S_POP: begin
        // Popped character is in the read register; issue the next read as it leaves.
        if (slot_free) begin
          load             = 1'b1;
          emit.last_of_run = (count_r == '0) && !emit_ch_r;
          if (count_r != '0) begin
            rd_en     = 1'b1;
            count_nxt = count_r - CW'(1);
          end else if (emit_ch_r) begin
            state_nxt = S_EMIT;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_EMIT: begin
        if (slot_free) begin
          load             = 1'b1;
          emit.char_out    = ch_r;
          emit.last_of_run = 1'b1;
          state_nxt        = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      count_r   <= '0;
      tag_r     <= 1'b0;
      ovf_r     <= 1'b0;
      emit_ch_r <= 1'b0;
      ch_r      <= '0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      tag_r     <= tag_nxt;
      ovf_r     <= ovf_nxt;
      emit_ch_r <= emit_ch_nxt;
      ch_r      <= ch_nxt;
    end
  end

  wrv_stack_mem #(
    .DEPTH(STACK_DEPTH),
    .AW   (AW)
  ) u_mem (
    .clk      (clk),
    .wr_en    (wr_en),
    .wr_addr  (count_r[AW-1:0]),
    .wr_data  (in_tdata),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_data_r(rd_data)
  );

  wrv_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (load),
    .emit      (emit),
    .slot_free (slot_free),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .out_tuser (out_tuser)
  );

endmodule

>>> design/wrv_checker.sv
// Port-level checker for the word reverser, bound to the top level.
// Depends on wrv_pkg for the default stack depth.
`timescale 1ns / 1ps

module wrv_checker #(
  parameter int STACK_DEPTH = wrv_pkg::STACK_DEPTH_DEF
) (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic [7:0] in_tdata,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tlast,
  input logic       out_tuser
);
  import wrv_pkg::*;

  localparam int RW = $clog2(STACK_DEPTH + 2);

  logic          ovf_seen_r;
  logic [RW-1:0] run_cnt_r;
  logic          out_acc;

  assign out_acc = out_tvalid && out_tready;

  // Track the sticky flag and the number of words in the current run.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovf_seen_r <= 1'b0;
      run_cnt_r  <= '0;
    end else if (out_acc) begin
      ovf_seen_r <= ovf_seen_r || out_tuser;
      run_cnt_r  <= out_tlast ? '0 : run_cnt_r + RW'(1);
    end
  end

  // A stalled input word holds until it is taken.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && !in_tready |=> in_tvalid && $stable(in_tdata))
    else $error("input word changed while stalled");

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result word changed while stalled");

  // No word comes out right after reset.
  a_reset_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(rst_n) |-> !out_tvalid)
    else $error("result word valid right after reset");

  // The overflow flag never drops once it was shown.
  a_ovf_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && ovf_seen_r |-> out_tuser)
    else $error("overflow flag dropped");

  // A run holds at most the stack contents plus one trailing character.
  a_run_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> run_cnt_r <= RW'(STACK_DEPTH))
    else $error("run longer than the stack allows");

endmodule

bind word_reverser_with_tag_passthrough_unit wrv_checker #(
  .STACK_DEPTH(STACK_DEPTH)
) u_wrv_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tvalid (in_tvalid),
  .in_tready (in_tready),
  .in_tdata  (in_tdata),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .out_tlast (out_tlast),
  .out_tuser (out_tuser)
);
